FILE: hw/rtl/bb3_pkg.sv
// Shared types and constants for the 3x3 RGB box blur.
// No dependencies; every other file in hw/rtl uses this package.
`default_nettype none

package bb3_pkg;

  // Default size limits, handed to the top-level parameters
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Register reset values (before saturation to the size limits)
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  // Configuration port
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  // Datapath widths
  localparam int CH_W  = 8;   // one color channel
  localparam int COL_W = 10;  // sum of three channel values
  localparam int TOT_W = 12;  // sum of nine channel values
  localparam int CNT_W = 4;   // pixels in a window, 1..9

  // Division by 2*count = 2^shift * {1,3,9}
  localparam logic [1:0] DIV_ONE   = 2'd0;
  localparam logic [1:0] DIV_THREE = 2'd1;
  localparam logic [1:0] DIV_NINE  = 2'd2;

  // floor(y/3) = (y*2731)>>13 and floor(y/9) = (y*3641)>>15, exact for y < 8192
  localparam int RCP_W = 12;
  localparam logic [RCP_W-1:0] RCP3 = 12'd2731;
  localparam logic [RCP_W-1:0] RCP9 = 12'd3641;
  localparam int RCP3_SH = 13;
  localparam int RCP9_SH = 15;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } col_t;

  typedef struct packed {
    logic [TOT_W-1:0] red;
    logic [TOT_W-1:0] green;
    logic [TOT_W-1:0] blue;
  } tot_t;

  // Per-word control, worked out when the word is taken
  typedef struct packed {
    logic             emit;    // word produces an output pixel
    logic             last;    // that pixel ends the frame
    logic [2:0]       row_en;  // rows of the new column inside the frame: [0] top
    logic             col_l;   // left window column inside the frame
    logic             col_r;   // right (new) column inside the frame
    logic [CNT_W-1:0] cnt;     // in-frame pixels of the window
  } ctl_t;

  typedef struct packed {
    logic [1:0] shift;
    logic [1:0] kind;
  } div_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bb3_ctrl.sv
// Frame size registers, raster position counters and per-word control.
// Depends on bb3_pkg.
`default_nettype none

module bb3_ctrl #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [bb3_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [bb3_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               accept,
  input  wire logic                               drain,
  output logic                                    take,
  output logic [$clog2(MAX_WIDTH)-1:0]            col_addr,
  output bb3_pkg::ctl_t                           ctl
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int CWX = (WW > bb3_pkg::CFG_WIDTH_W) ? WW : bb3_pkg::CFG_WIDTH_W;
  localparam int CHX = (HW > bb3_pkg::CFG_HEIGHT_W) ? HW : bb3_pkg::CFG_HEIGHT_W;
  localparam int RST_W = (bb3_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                         MAX_WIDTH : bb3_pkg::FRAME_WIDTH_RST;
  localparam int RST_H = (bb3_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
                         MAX_HEIGHT : bb3_pkg::FRAME_HEIGHT_RST;

  logic [WW-1:0]  width_r;
  logic [HW-1:0]  height_r;
  logic [AW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;

  logic [CWX-1:0] w_raw;
  logic [CHX-1:0] h_raw;
  logic [WW-1:0]  w_sat;
  logic [HW-1:0]  h_sat;

  logic [RW-1:0]  h_x;
  logic [AW:0]    c_inc;
  logic           c_nz, c_ge2, w_ge2;
  logic           r_lt_h, r_le_h, r_ge1, r_ge2, r_ge3;
  logic [1:0]     nrows, ncols;

  // Zero counts as one, anything above the limit saturates
  assign w_raw = CWX'(cfg_data[bb3_pkg::CFG_WIDTH_W-1:0]);
  assign h_raw = CHX'(cfg_data[bb3_pkg::CFG_HEIGHT_W-1:0]);

  always_comb begin
    if (w_raw == '0) begin
      w_sat = WW'(1);
    end else if (w_raw > CWX'(MAX_WIDTH)) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(w_raw);
    end
    if (h_raw == '0) begin
      h_sat = HW'(1);
    end else if (h_raw > CHX'(MAX_HEIGHT)) begin
      h_sat = HW'(MAX_HEIGHT);
    end else begin
      h_sat = HW'(h_raw);
    end
  end

  assign h_x    = RW'(height_r);
  assign c_nz   = (col_r != '0);
  assign c_ge2  = (col_r >= AW'(2));
  assign w_ge2  = (width_r >= WW'(2));
  assign r_lt_h = (row_r < h_x);
  assign r_le_h = (row_r <= h_x);
  assign r_ge1  = (row_r != '0);
  assign r_ge2  = (row_r >= RW'(2));
  assign r_ge3  = (row_r >= RW'(3));

  // Output pixel sits one row and one column back; at column 0 it is the
  // last pixel of the row two back.
  always_comb begin
    ctl.emit   = c_nz ? r_ge1 : r_ge2;
    ctl.last   = !c_nz && (row_r == h_x + RW'(1));
    ctl.row_en = {r_lt_h, r_ge1 && r_le_h, r_ge2};
    ctl.col_l  = c_nz ? c_ge2 : w_ge2;
    ctl.col_r  = c_nz;
    nrows      = 2'd1 + {1'b0, (c_nz ? r_ge2 : r_ge3)} + {1'b0, (c_nz ? r_lt_h : r_le_h)};
    ncols      = 2'd1 + {1'b0, ctl.col_l} + {1'b0, ctl.col_r};
    ctl.cnt    = bb3_pkg::CNT_W'({2'b00, nrows} * {2'b00, ncols});
  end

  // A drain word inside the frame is swallowed
  assign take     = accept && !(r_lt_h && drain);
  assign col_addr = col_r;

  always_comb begin
    c_inc = {1'b0, col_r} + (AW + 1)'(1);
    if (ctl.last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (c_inc >= (AW + 1)'(width_r)) begin
      col_nxt = '0;
      row_nxt = row_r + RW'(1);
    end else begin
      col_nxt = col_r + AW'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(RST_W);
      height_r <= HW'(RST_H);
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bb3_pkg::CFG_FRAME_WIDTH: begin
          width_r <= w_sat;
          col_r   <= '0;
          row_r   <= '0;
        end
        bb3_pkg::CFG_FRAME_HEIGHT: begin
          height_r <= h_sat;
          col_r    <= '0;
          row_r    <= '0;
        end
      endcase
    end else if (take) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_line.sv
// Two line stores (pixels one and two rows back) and the first pipe stage.
// Depends on bb3_pkg.
`default_nettype none

module bb3_line #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        take,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] col_addr,
  input  wire bb3_pkg::pix_t               pix,
  input  wire bb3_pkg::ctl_t               ctl_in,
  input  wire logic                        a_leave,
  output logic                             a_valid,
  output bb3_pkg::pix_t                    up_px,
  output bb3_pkg::pix_t                    mid_px,
  output bb3_pkg::pix_t                    cur_px,
  output bb3_pkg::ctl_t                    ctl_a
);

  localparam int AW = $clog2(MAX_WIDTH);

  bb3_pkg::pix_t upper_mem [MAX_WIDTH];
  bb3_pkg::pix_t middle_mem [MAX_WIDTH];

  logic          a_valid_r;
  logic [AW-1:0] addr_a_r;
  bb3_pkg::pix_t up_rd_r, mid_rd_r, cur_r;
  bb3_pkg::ctl_t ctl_a_r;
  logic          fwd;

  // Width 1 or a frame's end: the next word reads the column being written
  assign fwd = a_leave && (addr_a_r == col_addr);

  always_ff @(posedge clk) begin
    if (a_leave) begin
      upper_mem[addr_a_r]  <= mid_rd_r;
      middle_mem[addr_a_r] <= cur_r;
    end
    if (take) begin
      if (fwd) begin
        up_rd_r  <= mid_rd_r;
        mid_rd_r <= cur_r;
      end else begin
        up_rd_r  <= upper_mem[col_addr];
        mid_rd_r <= middle_mem[col_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      addr_a_r <= col_addr;
      cur_r    <= pix;
      ctl_a_r  <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= take || (a_valid_r && !a_leave);
    end
  end

  assign a_valid = a_valid_r;
  assign up_px   = up_rd_r;
  assign mid_px  = mid_rd_r;
  assign cur_px  = cur_r;
  assign ctl_a   = ctl_a_r;

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_window.sv
// Column sums, the two-column window and the 3x3 window total.
// Depends on bb3_pkg.
`default_nettype none

module bb3_window (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          a_leave,
  input  wire bb3_pkg::pix_t up_px,
  input  wire bb3_pkg::pix_t mid_px,
  input  wire bb3_pkg::pix_t cur_px,
  input  wire bb3_pkg::ctl_t ctl_a,
  input  wire logic          b_leave,
  output logic               b_valid,
  output bb3_pkg::tot_t      tot,
  output bb3_pkg::ctl_t      ctl_b
);

  localparam int COL_W = bb3_pkg::COL_W;
  localparam int TOT_W = bb3_pkg::TOT_W;

  bb3_pkg::col_t win0_r, win1_r, new_col;
  bb3_pkg::tot_t tot_r, tot_nxt;
  bb3_pkg::ctl_t ctl_b_r;
  logic          b_valid_r;

  function automatic logic [COL_W-1:0] col_add(
    input logic [bb3_pkg::CH_W-1:0] t,
    input logic [bb3_pkg::CH_W-1:0] m,
    input logic [bb3_pkg::CH_W-1:0] b,
    input logic [2:0]               en
  );
    logic [COL_W-1:0] s;
    s = (en[0] ? COL_W'(t) : '0) + (en[1] ? COL_W'(m) : '0) + (en[2] ? COL_W'(b) : '0);
    return s;
  endfunction

  function automatic logic [TOT_W-1:0] win_add(
    input logic [COL_W-1:0] l,
    input logic [COL_W-1:0] c,
    input logic [COL_W-1:0] r,
    input logic             l_en,
    input logic             r_en
  );
    logic [TOT_W-1:0] s;
    s = (l_en ? TOT_W'(l) : '0) + TOT_W'(c) + (r_en ? TOT_W'(r) : '0);
    return s;
  endfunction

  // Rows outside the frame drop out of the column sum
  always_comb begin
    new_col.red   = col_add(up_px.red,   mid_px.red,   cur_px.red,   ctl_a.row_en);
    new_col.green = col_add(up_px.green, mid_px.green, cur_px.green, ctl_a.row_en);
    new_col.blue  = col_add(up_px.blue,  mid_px.blue,  cur_px.blue,  ctl_a.row_en);
    tot_nxt.red   = win_add(win0_r.red,   win1_r.red,   new_col.red,   ctl_a.col_l, ctl_a.col_r);
    tot_nxt.green = win_add(win0_r.green, win1_r.green, new_col.green, ctl_a.col_l,
                            ctl_a.col_r);
    tot_nxt.blue  = win_add(win0_r.blue,  win1_r.blue,  new_col.blue,  ctl_a.col_l,
                            ctl_a.col_r);
  end

  always_ff @(posedge clk) begin
    if (a_leave) begin
      win0_r  <= win1_r;
      win1_r  <= new_col;
      tot_r   <= tot_nxt;
      ctl_b_r <= ctl_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_leave || (b_valid_r && !b_leave);
    end
  end

  assign b_valid = b_valid_r;
  assign tot     = tot_r;
  assign ctl_b   = ctl_b_r;

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_mean.sv
// Rounded mean per channel and the output register.
// Depends on bb3_pkg.
`default_nettype none

module bb3_mean (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     load,
  input  wire bb3_pkg::tot_t            tot,
  input  wire bb3_pkg::ctl_t            ctl_b,
  input  wire logic                     out_ready,
  output logic                          o_free,
  output logic                          out_valid,
  output logic [bb3_pkg::CH_W-1:0]      out_red_out,
  output logic [bb3_pkg::CH_W-1:0]      out_green_out,
  output logic [bb3_pkg::CH_W-1:0]      out_blue_out,
  output logic                          out_frame_last
);

  localparam int TOT_W = bb3_pkg::TOT_W;
  localparam int CH_W  = bb3_pkg::CH_W;
  localparam int PW    = TOT_W + bb3_pkg::RCP_W;

  bb3_pkg::div_t        dv;
  logic                 out_valid_r;
  logic [CH_W-1:0]      red_r, green_r, blue_r;
  logic                 last_r;
  logic [CH_W-1:0]      red_nxt, green_nxt, blue_nxt;

  // 2*count split into a power of two and an odd factor
  always_comb begin
    unique case (ctl_b.cnt)
      4'd2:    dv = '{shift: 2'd2, kind: bb3_pkg::DIV_ONE};
      4'd3:    dv = '{shift: 2'd1, kind: bb3_pkg::DIV_THREE};
      4'd4:    dv = '{shift: 2'd3, kind: bb3_pkg::DIV_ONE};
      4'd6:    dv = '{shift: 2'd2, kind: bb3_pkg::DIV_THREE};
      4'd9:    dv = '{shift: 2'd1, kind: bb3_pkg::DIV_NINE};
      default: dv = '{shift: 2'd1, kind: bb3_pkg::DIV_ONE};
    endcase
  end

  // floor((2*sum + cnt) / (2*cnt))
  function automatic logic [CH_W-1:0] mean(
    input logic [TOT_W-1:0]         s,
    input logic [bb3_pkg::CNT_W-1:0] n,
    input bb3_pkg::div_t            d
  );
    logic [TOT_W:0]              x;
    logic [TOT_W-1:0]            y;
    logic [bb3_pkg::RCP_W-1:0]   rcp;
    logic [PW-1:0]               p;
    logic [CH_W-1:0]             q;
    x   = {s, 1'b0} + (TOT_W + 1)'(n);
    y   = TOT_W'(x >> d.shift);
    rcp = (d.kind == bb3_pkg::DIV_NINE) ? bb3_pkg::RCP9 : bb3_pkg::RCP3;
    p   = PW'(y) * PW'(rcp);
    unique case (d.kind)
      bb3_pkg::DIV_THREE: q = p[bb3_pkg::RCP3_SH +: CH_W];
      bb3_pkg::DIV_NINE:  q = p[bb3_pkg::RCP9_SH +: CH_W];
      default:            q = y[CH_W-1:0];
    endcase
    return q;
  endfunction

  always_comb begin
    red_nxt   = mean(tot.red,   ctl_b.cnt, dv);
    green_nxt = mean(tot.green, ctl_b.cnt, dv);
    blue_nxt  = mean(tot.blue,  ctl_b.cnt, dv);
  end

  assign o_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (load) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      last_r  <= ctl_b.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= load || (out_valid_r && !out_ready);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_out    = red_r;
  assign out_green_out  = green_r;
  assign out_blue_out   = blue_r;
  assign out_frame_last = last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/box_blur_3x3_rgb_unit.sv
// 3x3 box blur over an RGB raster stream, top level.
// Depends on bb3_pkg, bb3_ctrl, bb3_line, bb3_window and bb3_mean.
//
// Takes one RGB word per clock in raster order and returns, for every pixel
// of the frame, the half-up rounded mean of the in-frame pixels of its 3x3
// neighborhood (4 at a corner, 6 on an edge, 9 inside), per channel. Output
// pixel p leaves with the word that follows input pixel p by width+1 words,
// so after the last pixel of a frame the source sends width+1 words with
// in_drain set to flush it; out_frame_last marks the final pixel, and the
// next word starts a new frame. A drain word inside a frame is taken and
// dropped; a pixel word during the flush counts as a drain word. Throughput
// is one word per clock while out_ready keeps up, set by the single write
// port and single read port of each line store; the pipe is three registers
// deep (line store read, window total, mean). Back-pressure on out_ready
// ripples stage by stage, and empty stages keep taking words while a result
// waits. The line stores are MAX_WIDTH x 24 bit each with no reset and no
// clearing pass: rows above or below the frame are masked out of the sums,
// so stale contents never reach an output. Writing either size register
// restarts the frame; write it only while the pipe is empty.
`default_nettype none

module box_blur_3x3_rgb_unit #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration writes
  input  wire logic                             cfg_wr_en,
  input  wire logic [bb3_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data,
  // pixel words in
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [bb3_pkg::CH_W-1:0]         in_red_in,
  input  wire logic [bb3_pkg::CH_W-1:0]         in_green_in,
  input  wire logic [bb3_pkg::CH_W-1:0]         in_blue_in,
  input  wire logic                             in_drain,
  // blurred words out
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [bb3_pkg::CH_W-1:0]              out_red_out,
  output logic [bb3_pkg::CH_W-1:0]              out_green_out,
  output logic [bb3_pkg::CH_W-1:0]              out_blue_out,
  output logic                                  out_frame_last
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic          accept, take;
  logic [AW-1:0] col_addr;
  bb3_pkg::ctl_t ctl_in, ctl_a, ctl_b;
  bb3_pkg::pix_t pix, up_px, mid_px, cur_px;
  bb3_pkg::tot_t tot;
  logic          a_valid, a_leave;
  logic          b_valid, b_leave, b_free;
  logic          o_free, o_load;

  // Stage flow: a word leaves a stage when the next one is empty or moving.
  // Words that produce no pixel pass the output register by.
  assign b_leave  = b_valid && (!ctl_b.emit || o_free);
  assign b_free   = !b_valid || b_leave;
  assign a_leave  = a_valid && b_free;
  assign in_ready = !a_valid || b_free;
  assign accept   = in_valid && in_ready;
  assign o_load   = b_leave && ctl_b.emit;

  assign pix = '{red: in_red_in, green: in_green_in, blue: in_blue_in};

  bb3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .drain     (in_drain),
    .take      (take),
    .col_addr  (col_addr),
    .ctl       (ctl_in)
  );

  bb3_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .col_addr (col_addr),
    .pix      (pix),
    .ctl_in   (ctl_in),
    .a_leave  (a_leave),
    .a_valid  (a_valid),
    .up_px    (up_px),
    .mid_px   (mid_px),
    .cur_px   (cur_px),
    .ctl_a    (ctl_a)
  );

  bb3_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .a_leave (a_leave),
    .up_px   (up_px),
    .mid_px  (mid_px),
    .cur_px  (cur_px),
    .ctl_a   (ctl_a),
    .b_leave (b_leave),
    .b_valid (b_valid),
    .tot     (tot),
    .ctl_b   (ctl_b)
  );

  bb3_mean u_mean (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (o_load),
    .tot            (tot),
    .ctl_b          (ctl_b),
    .out_ready      (out_ready),
    .o_free         (o_free),
    .out_valid      (out_valid),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_frame_last (out_frame_last)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/bb3_checker.sv
// Port-level checks for the box blur top level, attached with bind.
// Depends on bb3_pkg and box_blur_3x3_rgb_unit.
`default_nettype none

module bb3_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [bb3_pkg::CH_W-1:0]    out_red_out,
  input wire logic [bb3_pkg::CH_W-1:0]    out_green_out,
  input wire logic [bb3_pkg::CH_W-1:0]    out_blue_out,
  input wire logic                        out_frame_last
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // When the sink takes words the pipe never holds off the source
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_red_out) && $stable(out_green_out) && $stable(out_blue_out)
      && $stable(out_frame_last))
    else $error("stalled output word changed");

endmodule

bind box_blur_3x3_rgb_unit bb3_checker u_bb3_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_red_out    (out_red_out),
  .out_green_out  (out_green_out),
  .out_blue_out   (out_blue_out),
  .out_frame_last (out_frame_last)
);

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking bench for box_blur_3x3_rgb_unit: random frames, idling on both sides.
// Depends on bb3_pkg and the RTL top level only; predicts every blurred word locally.
`default_nettype none

module tb_top;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 6;
  localparam int PIPE_FLUSH     = 16;       // well past the three-stage pipe
  localparam int RAND_WORDS     = 510;      // counted words in the random part
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int RESET_PARTIAL  = 645;      // enough at 640 wide to release a few outputs
  localparam int EXTREME_WORDS  = 12;       // start of a frame at the size extremes

  // one word on the input channel
  typedef struct packed {
    bb3_pkg::pix_t px;
    logic          drain;
  } pix_word_t;

  // one word on the output channel
  typedef struct packed {
    logic [bb3_pkg::CH_W-1:0] red;
    logic [bb3_pkg::CH_W-1:0] green;
    logic [bb3_pkg::CH_W-1:0] blue;
    logic                     last;
  } blur_px_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            cfg_wr_en = 1'b0;
  logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index = bb3_pkg::CFG_FRAME_WIDTH;
  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic [bb3_pkg::CH_W-1:0] in_red_in   = '0;
  logic [bb3_pkg::CH_W-1:0] in_green_in = '0;
  logic [bb3_pkg::CH_W-1:0] in_blue_in  = '0;
  logic                     in_drain    = 1'b0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [bb3_pkg::CH_W-1:0] out_red_out;
  logic [bb3_pkg::CH_W-1:0] out_green_out;
  logic [bb3_pkg::CH_W-1:0] out_blue_out;
  logic                     out_frame_last;

  box_blur_3x3_rgb_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_drain       (in_drain),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_frame_last (out_frame_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Blur predictor: its own copy of the line stores, window and raster position
  // ---------------------------------------------------------------------------
  bb3_pkg::pix_t upper_rows  [bb3_pkg::MAX_WIDTH_DEF];  // two rows back
  bb3_pkg::pix_t middle_rows [bb3_pkg::MAX_WIDTH_DEF];  // one row back
  bb3_pkg::pix_t win_cols    [6];   // left column [0..2], middle column [3..5]
  int            col_pos;
  int            row_pos;
  logic [bb3_pkg::CFG_WIDTH_W-1:0]  width_reg;
  logic [bb3_pkg::CFG_HEIGHT_W-1:0] height_reg;

  pix_word_t pixel_words   [$];   // words waiting for the driver
  blur_px_t  blur_expected [$];   // predicted outputs, oldest first

  int send_idle_pct = 22;
  int recv_idle_pct = 61;
  int mismatches    = 0;
  int fed_words     = 0;
  int taken_words   = 0;
  int pixels_seen   = 0;
  int frames_done   = 0;
  int cfg_writes    = 0;

  // sizes as the block uses them: zero counts as 1, large values saturate
  function automatic int frame_cols();
    if (width_reg == 0) return 1;
    return (width_reg > bb3_pkg::MAX_WIDTH_DEF) ? bb3_pkg::MAX_WIDTH_DEF : int'(width_reg);
  endfunction

  function automatic int frame_rows();
    if (height_reg == 0) return 1;
    return (height_reg > bb3_pkg::MAX_HEIGHT_DEF) ? bb3_pkg::MAX_HEIGHT_DEF
                                                  : int'(height_reg);
  endfunction

  // line stores survive a restart; window and position do not
  function automatic void frame_restart();
    int k;
    for (k = 0; k < 6; k++) win_cols[k] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Advance the raster by one accepted word; returns 1 when a blurred pixel
  // comes out, which is then in res.
  function automatic bit blur_step(input bb3_pkg::pix_t px, input logic drain,
                                   output blur_px_t res);
    int            w, h, r, c, orow, ocol, cc, rr, cnt, sr, sg, sb, k, dc, dr;
    bb3_pkg::pix_t newcol [3];
    bb3_pkg::pix_t cols   [3][3];
    bit            emit, last;
    w = frame_cols();
    h = frame_rows();
    r = row_pos;
    c = col_pos;
    emit = 1'b0;
    last = 1'b0;
    res  = '0;
    if (c >= w) c = 0;
    // drain inside the frame: taken, no effect at all
    if (r < h && drain) return 1'b0;
    // past the last row every word flushes; pixel data is dropped
    newcol[0] = upper_rows[c];
    newcol[1] = middle_rows[c];
    newcol[2] = (r < h) ? px : '0;
    upper_rows[c]  = newcol[1];
    middle_rows[c] = newcol[2];
    for (k = 0; k < 3; k++) begin
      cols[0][k] = win_cols[k];
      cols[1][k] = win_cols[3 + k];
      cols[2][k] = newcol[k];
    end
    // column 0 closes the last pixel of the row before the previous one
    if (c >= 1) begin
      orow = r - 1;
      ocol = c - 1;
    end else begin
      orow = r - 2;
      ocol = w - 1;
    end
    if (orow >= 0) begin
      sr = 0;
      sg = 0;
      sb = 0;
      cnt = 0;
      for (dc = 0; dc < 3; dc++) begin
        cc = ocol + dc - 1;
        if (cc >= 0 && cc < w) begin
          for (dr = 0; dr < 3; dr++) begin
            rr = orow + dr - 1;
            if (rr >= 0 && rr < h) begin
              sr += cols[dc][dr].red;
              sg += cols[dc][dr].green;
              sb += cols[dc][dr].blue;
              cnt++;
            end
          end
        end
      end
      if (cnt == 0) cnt = 1;
      last = (orow == h - 1) && (ocol == w - 1);
      // half-up rounding of sum/cnt
      res.red   = 8'((2 * sr + cnt) / (2 * cnt));
      res.green = 8'((2 * sg + cnt) / (2 * cnt));
      res.blue  = 8'((2 * sb + cnt) / (2 * cnt));
      res.last  = last;
      emit = 1'b1;
    end
    for (k = 0; k < 3; k++) begin
      win_cols[k]     = win_cols[3 + k];
      win_cols[3 + k] = newcol[k];
    end
    if (last || r > h + 1) begin
      frame_restart();
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col_pos = c;
      row_pos = r;
    end
    return emit;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one word per handshake, random gaps, payload held while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    pix_word_t word;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        word = pixel_words.pop_front();
        in_valid    <= 1'b1;
        in_red_in   <= word.px.red;
        in_green_in <= word.px.green;
        in_blue_in  <= word.px.blue;
        in_drain    <= word.drain;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input handshakes, check on output handshakes. Both in
  // one block so a same-edge push and pop keep a fixed order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    bb3_pkg::pix_t px_in;
    blur_px_t      want;
    blur_px_t      got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        taken_words++;
        px_in = {in_red_in, in_green_in, in_blue_in};
        if (blur_step(px_in, in_drain, want)) blur_expected.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {out_red_out, out_green_out, out_blue_out, out_frame_last};
        if (blur_expected.size() == 0) begin
          $error("output word with nothing expected: rgb %0d %0d %0d last %0d",
                 got.red, got.green, got.blue, got.last);
          mismatches++;
        end else begin
          want = blur_expected.pop_front();
          pixels_seen++;
          if (got.last) frames_done++;
          if (got.red !== want.red) begin
            $error("red_out mismatch: expected %0d, got %0d", want.red, got.red);
            mismatches++;
          end
          if (got.green !== want.green) begin
            $error("green_out mismatch: expected %0d, got %0d", want.green, got.green);
            mismatches++;
          end
          if (got.blue !== want.blue) begin
            $error("blue_out mismatch: expected %0d, got %0d", want.blue, got.blue);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("frame_last mismatch: expected %0d, got %0d", want.last, got.last);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // channel value leaning on the extremes
  function automatic logic [bb3_pkg::CH_W-1:0] rand_chan();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return bb3_pkg::CH_W'($urandom_range(255));
    endcase
  endfunction

  // frame size pick: mostly tiny, sometimes mid, now and then zero
  function automatic int size_pick(input int top);
    if ($urandom_range(19) == 0) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(top, 9);
    return $urandom_range(8, 1);
  endfunction

  task automatic feed(input bb3_pkg::pix_t px, input logic drain);
    pixel_words.push_back({px, drain});
  endtask

  // n random pixel words, no drain
  task automatic feed_pixels(input int n);
    int i;
    for (i = 0; i < n; i++) feed({rand_chan(), rand_chan(), rand_chan()}, 1'b0);
  endtask

  // pipe must be empty before a register write
  task automatic settle();
    do @(negedge clk);
    while (pixel_words.size() != 0 || in_valid || blur_expected.size() != 0);
    repeat (PIPE_FLUSH) @(negedge clk);
  endtask

  // register write; restarts the frame in the block and in the predictor
  task automatic cfg_write(input logic [bb3_pkg::CFG_INDEX_W-1:0] idx,
                           input int unsigned value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[bb3_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == bb3_pkg::CFG_FRAME_WIDTH) width_reg = value[bb3_pkg::CFG_WIDTH_W-1:0];
    else                                 height_reg = value[bb3_pkg::CFG_HEIGHT_W-1:0];
    frame_restart();
    cfg_writes++;
    @(negedge clk);
  endtask

  // Full frame: pixels with the odd ignored drain mixed in, then width+1 flush
  // words, some of them pixel words whose data must be dropped.
  task automatic queue_frame(input int w, input int h);
    int i;
    for (i = 0; i < w * h; i++) begin
      if ($urandom_range(15) == 0) feed({rand_chan(), rand_chan(), rand_chan()}, 1'b1);
      feed({rand_chan(), rand_chan(), rand_chan()}, 1'b0);
      fed_words++;
    end
    for (i = 0; i <= w; i++) begin
      feed({rand_chan(), rand_chan(), rand_chan()}, $urandom_range(4) != 0);
      fed_words++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i, phase, target;
    for (i = 0; i < bb3_pkg::MAX_WIDTH_DEF; i++) begin
      upper_rows[i]  = '0;
      middle_rows[i] = '0;
    end
    width_reg  = bb3_pkg::FRAME_WIDTH_RST;
    height_reg = bb3_pkg::FRAME_HEIGHT_RST;
    frame_restart();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset sizes (640 wide): part of a frame, enough for the first outputs,
    // then a register write cuts it off mid-frame.
    feed_pixels(RESET_PARTIAL);
    settle();

    // 2x2: corners only, divide by 4; half-way sums round up
    cfg_write(bb3_pkg::CFG_FRAME_WIDTH, 2);
    cfg_write(bb3_pkg::CFG_FRAME_HEIGHT, 2);
    feed({8'd255, 8'd0, 8'd1}, 1'b0);
    feed({8'd9, 8'd9, 8'd9}, 1'b1);          // drain inside the frame, ignored
    feed({8'd0, 8'd255, 8'd0}, 1'b0);
    feed({8'd255, 8'd255, 8'd0}, 1'b0);
    feed({8'd0, 8'd0, 8'd1}, 1'b0);
    feed({8'd0, 8'd0, 8'd0}, 1'b1);
    feed({8'd77, 8'd88, 8'd99}, 1'b0);       // pixel during flush, data dropped
    feed({8'd255, 8'd255, 8'd255}, 1'b1);
    queue_frame(2, 2);                       // back-to-back frame after frame_last
    settle();

    // 3x3: corners, edges and a full centre window
    cfg_write(bb3_pkg::CFG_FRAME_WIDTH, 3);
    cfg_write(bb3_pkg::CFG_FRAME_HEIGHT, 3);
    for (i = 0; i < 9; i++)
      feed({8'(i * 31), 8'(255 - i * 31), (i % 2) ? 8'd255 : 8'd0}, 1'b0);
    for (i = 0; i < 4; i++) feed({8'd255, 8'd0, 8'd255}, 1'b1);

    for (phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // size extremes, each cut off after the first words of a frame
          cfg_write(bb3_pkg::CFG_FRAME_WIDTH, 13'h1FFF);   // saturates to the widest row
          cfg_write(bb3_pkg::CFG_FRAME_HEIGHT, 13'h1FFF);  // saturates to the tallest frame
          feed_pixels(EXTREME_WORDS);
          settle();
          // one column under the saturated height: outputs from the third row on
          cfg_write(bb3_pkg::CFG_FRAME_WIDTH, 1);
          feed_pixels(EXTREME_WORDS);
          settle();
          cfg_write(bb3_pkg::CFG_FRAME_WIDTH, 0);          // zero sizes act as 1
          cfg_write(bb3_pkg::CFG_FRAME_HEIGHT, 0);
          queue_frame(frame_cols(), frame_rows());
          queue_frame(frame_cols(), frame_rows());
          settle();
          cfg_write(bb3_pkg::CFG_FRAME_WIDTH, bb3_pkg::MAX_WIDTH_DEF);
          cfg_write(bb3_pkg::CFG_FRAME_HEIGHT, 2);
          feed_pixels(EXTREME_WORDS);
          settle();
        end
      endcase
      target = fed_words + RAND_WORDS / 3;
      while (fed_words < target) begin
        settle();
        // top data bit rides along on width writes; the register drops it
        case ($urandom_range(3))
          0: cfg_write(bb3_pkg::CFG_FRAME_WIDTH, size_pick(40) | ($urandom_range(1) << 12));
          1: cfg_write(bb3_pkg::CFG_FRAME_HEIGHT, size_pick(12));
          default: begin
            cfg_write(bb3_pkg::CFG_FRAME_WIDTH, size_pick(40) | ($urandom_range(1) << 12));
            cfg_write(bb3_pkg::CFG_FRAME_HEIGHT, size_pick(12));
          end
        endcase
        repeat ($urandom_range(3, 1)) queue_frame(frame_cols(), frame_rows());
      end
    end

    settle();
    $display("Run: %0d input words taken, %0d register writes, %0d frames ended.",
             taken_words, cfg_writes, frames_done);
    $display("Checked %0d blurred pixels over random, zero and saturated frame sizes.",
             pixels_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/bb3_pkg.sv
hw/rtl/bb3_ctrl.sv
hw/rtl/bb3_line.sv
hw/rtl/bb3_window.sv
hw/rtl/bb3_mean.sv
hw/rtl/box_blur_3x3_rgb_unit.sv
hw/rtl/bb3_checker.sv
verif/tb_top.sv
